@@ hdl/fixed_point_alu_macros.svh @@
// Assertion macros for the checker file of the fixed-point ALU.
// Depends on nothing; expects clk and arst_n in the scope of use.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define FXA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fixed_point_alu check failed");

// Next-cycle implication, quiet during reset.
`define FXA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fixed_point_alu check failed");

`endif

@@ hdl/fxa_pkg.sv @@
// Shared types and constants of the fixed-point ALU.
// Depends on nothing; every RTL module imports it.
package fxa_pkg;

	typedef enum logic [3:0] {
		CMD_ADD    = 4'd0,
		CMD_SUB    = 4'd1,
		CMD_MUL    = 4'd2,
		CMD_DIV    = 4'd3,
		CMD_GT     = 4'd4,
		CMD_LT     = 4'd5,
		CMD_GE     = 4'd6,
		CMD_LE     = 4'd7,
		CMD_EQ     = 4'd8,
		CMD_NE     = 4'd9,
		CMD_MAX    = 4'd10,
		CMD_MIN    = 4'd11,
		CMD_INC    = 4'd12,
		CMD_DEC    = 4'd13,
		CMD_TO_INT = 4'd14
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic cond;
		logic div_zero;
		logic neg;
	} fxa_ctrl_t;

	// quotient bits retired per divider stage
	localparam int DIV_STEPS = 2;

	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 40;
	localparam int OPERAND_W   = 32;

endpackage

@@ hdl/fxa_decode.sv @@
// First stage: operand extension, simple operations, compares, magnitudes.
// Depends on fxa_pkg.
module fxa_decode import fxa_pkg::*; #(
	parameter int W = 32,
	parameter int F = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [3:0]                  command,
	input  logic signed [OPERAND_W-1:0] operand_a,
	input  logic signed [OPERAND_W-1:0] operand_b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output fxa_ctrl_t                   ctrl_s1,
	output logic [W-1:0]                simple_s1,
	output logic [W-1:0]                mag_a_s1,
	output logic [W-1:0]                mag_b_s1
);

	localparam int EXT = (W > OPERAND_W) ? W : OPERAND_W;

	logic [EXT-1:0] a_ext, b_ext;
	logic [W-1:0]   a, b, simple;
	logic           lt, gt, cond;
	cmd_t           cmd;
	logic           valid_s1;

	assign a_ext = EXT'(operand_a);
	assign b_ext = EXT'(operand_b);
	assign a     = a_ext[W-1:0];
	assign b     = b_ext[W-1:0];
	assign cmd   = cmd_t'(command);
	assign lt    = $signed(a) < $signed(b);
	assign gt    = $signed(b) < $signed(a);

	always_comb begin
		cond   = 1'b0;
		simple = '0;
		case (cmd)
			CMD_ADD:    simple = a + b;
			CMD_SUB:    simple = a - b;
			CMD_MAX:    simple = gt ? a : b;
			CMD_MIN:    simple = lt ? a : b;
			CMD_INC:    simple = a + W'(1);
			CMD_DEC:    simple = a - W'(1);
			CMD_TO_INT: simple = W'($signed(a) >>> F);
			CMD_GT:     cond = gt;
			CMD_LT:     cond = lt;
			CMD_GE:     cond = !lt;
			CMD_LE:     cond = !gt;
			CMD_EQ:     cond = (a == b);
			CMD_NE:     cond = (a != b);
			default:    simple = '0;
		endcase
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ctrl_s1.cmd      <= cmd;
			ctrl_s1.cond     <= cond;
			ctrl_s1.div_zero <= (cmd == CMD_DIV) && (b == '0);
			ctrl_s1.neg      <= a[W-1] ^ b[W-1];
			simple_s1        <= simple;
			mag_a_s1         <= a[W-1] ? -a : a;
			mag_b_s1         <= b[W-1] ? -b : b;
		end
	end

endmodule

@@ hdl/fxa_mul.sv @@
// Two stages: four half-width partial products, then their sum scaled down.
// Depends on fxa_pkg.
module fxa_mul import fxa_pkg::*; #(
	parameter int W = 32,
	parameter int F = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  fxa_ctrl_t    ctrl_in,
	input  logic [W-1:0] simple_in,
	input  logic [W-1:0] mag_a_in,
	input  logic [W-1:0] mag_b_in,
	output logic         out_valid,
	input  logic         out_ready,
	output fxa_ctrl_t    ctrl_s3,
	output logic [W-1:0] simple_s3,
	output logic [W-1:0] mag_a_s3,
	output logic [W-1:0] mag_b_s3,
	output logic [W-1:0] prod_s3
);

	localparam int H  = (W + 1) / 2;
	localparam int PW = 2 * W + F;

	logic            valid_s2, valid_s3, ready_s2;
	logic [2*H-1:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	fxa_ctrl_t       ctrl_s2;
	logic [W-1:0]    simple_s2, mag_a_s2, mag_b_s2;
	logic [H-1:0]    xl, xh, yl, yh;
	logic [PW-1:0]   full;

	assign xl = mag_a_in[H-1:0];
	assign xh = H'(mag_a_in >> H);
	assign yl = mag_b_in[H-1:0];
	assign yh = H'(mag_b_in >> H);

	assign full = PW'(p00_s2)
		+ ((PW'(p01_s2) + PW'(p10_s2)) << H)
		+ (PW'(p11_s2) << (2 * H));

	assign ready_s2  = !valid_s3 || out_ready;
	assign in_ready  = !valid_s2 || ready_s2;
	assign out_valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (in_ready) valid_s2 <= in_valid;
			if (ready_s2) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			p00_s2    <= xl * yl;
			p01_s2    <= xl * yh;
			p10_s2    <= xh * yl;
			p11_s2    <= xh * yh;
			ctrl_s2   <= ctrl_in;
			simple_s2 <= simple_in;
			mag_a_s2  <= mag_a_in;
			mag_b_s2  <= mag_b_in;
		end
		if (ready_s2 && valid_s2) begin
			prod_s3   <= full[F +: W];
			ctrl_s3   <= ctrl_s2;
			simple_s3 <= simple_s2;
			mag_a_s3  <= mag_a_s2;
			mag_b_s3  <= mag_b_s2;
		end
	end

endmodule

@@ hdl/fxa_div_stage.sv @@
// One restoring-divider stage: retires DIV_STEPS quotient bits per item.
// Depends on fxa_pkg.
module fxa_div_stage import fxa_pkg::*; #(
	parameter int W  = 32,
	parameter int DW = 40,
	parameter int SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [W-1:0]  rem_in,
	input  logic [W-1:0]  quo_in,
	input  logic [DW-1:0] num_in,
	input  logic [W-1:0]  den_in,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [W-1:0]  rem_out,
	output logic [W-1:0]  quo_out,
	output logic [DW-1:0] num_out,
	output logic [W-1:0]  den_out,
	output logic [SW-1:0] side_out
);

	logic          valid_q;
	logic [W:0]    trial;
	logic [W-1:0]  rem_v, quo_v;
	logic [DW-1:0] num_v;

	always_comb begin
		rem_v = rem_in;
		quo_v = quo_in;
		num_v = num_in;
		trial = '0;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {rem_v, num_v[DW-1]};
			num_v = {num_v[DW-2:0], 1'b0};
			if (trial >= {1'b0, den_in}) begin
				rem_v = W'(trial - {1'b0, den_in});
				quo_v = {quo_v[W-2:0], 1'b1};
			end else begin
				rem_v = trial[W-1:0];
				quo_v = {quo_v[W-2:0], 1'b0};
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rem_out  <= rem_v;
			quo_out  <= quo_v;
			num_out  <= num_v;
			den_out  <= den_in;
			side_out <= side_in;
		end
	end

endmodule

@@ hdl/fxa_finish.sv @@
// Last stage: sign fix of product or quotient, result select, output register.
// Depends on fxa_pkg.
module fxa_finish import fxa_pkg::*; #(
	parameter int W = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  fxa_ctrl_t              ctrl_in,
	input  logic [W-1:0]           simple_in,
	input  logic [W-1:0]           prod_in,
	input  logic [W-1:0]           quo_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] tdata_q
);

	localparam int EXT = (W > OPERAND_W) ? W : OPERAND_W;

	logic           valid_q;
	logic [W-1:0]   mag, res;
	logic [EXT-1:0] res_ext;

	assign mag = (ctrl_in.cmd == CMD_MUL) ? prod_in : quo_in;

	always_comb begin
		case (ctrl_in.cmd)
			CMD_MUL: res = ctrl_in.neg ? -mag : mag;
			CMD_DIV: res = ctrl_in.div_zero ? '0 : (ctrl_in.neg ? -mag : mag);
			default: res = simple_in;
		endcase
	end

	// narrow words come out zero-extended
	assign res_ext = EXT'(res);

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tdata_q <= OUT_TDATA_W'({ctrl_in.div_zero, ctrl_in.cond, res_ext[OPERAND_W-1:0]});
		end
	end

endmodule

@@ hdl/fixed_point_alu.sv @@
// Top level of the pipelined signed fixed-point ALU.
// Depends on fxa_pkg, fxa_decode, fxa_mul, fxa_div_stage, fxa_finish.
//
//  channel  | direction | payload (lowest bit up)
//  s_axis   | in        | command[3:0], operand_a[35:4], operand_b[67:36], zero pad to 72
//  m_axis   | out       | result_raw[31:0], condition[32], divide_by_zero[33], zero pad to 40
//
// Every command runs the same pipe: one decode stage, two multiply stages,
// ceil((WORD_BITS+FRACTION_BITS)/2) divider stages and one output stage.
// One item enters per cycle while the output is not stalled. Each stage
// holds its own valid bit, so bubbles close up behind a stalled output and
// nothing is dropped or repeated. Reset clears only valid bits.
module fixed_point_alu import fxa_pkg::*; #(
	parameter int FRACTION_BITS = 8,
	parameter int WORD_BITS     = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// command[3:0], operand_a[35:4], operand_b[67:36], zeros above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// result_raw[31:0], condition[32], divide_by_zero[33], zeros above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int W    = WORD_BITS;
	localparam int F    = FRACTION_BITS;
	localparam int QB   = W + F;
	localparam int DSTG = (QB + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DW   = DSTG * DIV_STEPS;
	localparam int SW   = $bits(fxa_ctrl_t) + 2 * W;

	// decode -> multiply
	logic         dec_valid, dec_ready;
	fxa_ctrl_t    dec_ctrl;
	logic [W-1:0] dec_simple, dec_mag_a, dec_mag_b;

	// multiply -> divider
	logic         mul_valid;
	fxa_ctrl_t    mul_ctrl;
	logic [W-1:0] mul_simple, mul_mag_a, mul_mag_b, mul_prod;

	// divider chain, index 0 is the chain input
	logic          dv_valid [DSTG+1];
	logic          dv_ready [DSTG+1];
	logic [W-1:0]  dv_rem   [DSTG+1];
	logic [W-1:0]  dv_quo   [DSTG+1];
	logic [DW-1:0] dv_num   [DSTG+1];
	logic [W-1:0]  dv_den   [DSTG+1];
	logic [SW-1:0] dv_side  [DSTG+1];

	// divider -> finish
	fxa_ctrl_t    fin_ctrl;
	logic [W-1:0] fin_simple, fin_prod;

	fxa_decode #(.W(W), .F(F)) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.command   (s_axis_tdata[3:0]),
		.operand_a (s_axis_tdata[35:4]),
		.operand_b (s_axis_tdata[67:36]),
		.out_valid (dec_valid),
		.out_ready (dec_ready),
		.ctrl_s1   (dec_ctrl),
		.simple_s1 (dec_simple),
		.mag_a_s1  (dec_mag_a),
		.mag_b_s1  (dec_mag_b)
	);

	fxa_mul #(.W(W), .F(F)) u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.ctrl_in   (dec_ctrl),
		.simple_in (dec_simple),
		.mag_a_in  (dec_mag_a),
		.mag_b_in  (dec_mag_b),
		.out_valid (mul_valid),
		.out_ready (dv_ready[0]),
		.ctrl_s3   (mul_ctrl),
		.simple_s3 (mul_simple),
		.mag_a_s3  (mul_mag_a),
		.mag_b_s3  (mul_mag_b),
		.prod_s3   (mul_prod)
	);

	// Load the divider: dividend magnitude shifted up by the fraction width,
	// leading zeros fill the rounded-up bit count.
	assign dv_valid[0] = mul_valid;
	assign dv_rem[0]   = '0;
	assign dv_quo[0]   = '0;
	assign dv_num[0]   = DW'({mul_mag_a, {F{1'b0}}});
	assign dv_den[0]   = mul_mag_b;
	assign dv_side[0]  = {mul_ctrl, mul_simple, mul_prod};

	for (genvar g = 0; g < DSTG; g++) begin : g_div
		fxa_div_stage #(.W(W), .DW(DW), .SW(SW)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[g]),
			.in_ready  (dv_ready[g]),
			.rem_in    (dv_rem[g]),
			.quo_in    (dv_quo[g]),
			.num_in    (dv_num[g]),
			.den_in    (dv_den[g]),
			.side_in   (dv_side[g]),
			.out_valid (dv_valid[g+1]),
			.out_ready (dv_ready[g+1]),
			.rem_out   (dv_rem[g+1]),
			.quo_out   (dv_quo[g+1]),
			.num_out   (dv_num[g+1]),
			.den_out   (dv_den[g+1]),
			.side_out  (dv_side[g+1])
		);
	end

	assign {fin_ctrl, fin_simple, fin_prod} = dv_side[DSTG];

	fxa_finish #(.W(W)) u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dv_valid[DSTG]),
		.in_ready  (dv_ready[DSTG]),
		.ctrl_in   (fin_ctrl),
		.simple_in (fin_simple),
		.prod_in   (fin_prod),
		.quo_in    (dv_quo[DSTG]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.tdata_q   (m_axis_tdata)
	);

endmodule

@@ hdl/fxa_checker.sv @@
// Port-level checks of the fixed-point ALU, bound to the top level.
// Depends on fixed_point_alu_macros.svh and fxa_pkg.
`include "fixed_point_alu_macros.svh"

module fxa_checker import fxa_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result stays offered and unchanged
	`FXA_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`FXA_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	// a divide by zero never carries a comparison outcome or a nonzero word
	`FXA_ASSERT_NOW(a_dz_clean, m_axis_tvalid && m_axis_tdata[33], !m_axis_tdata[32] && m_axis_tdata[31:0] == 32'd0)
	// comparisons return a zero word
	`FXA_ASSERT_NOW(a_cond_zero, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[31:0] == 32'd0)

endmodule

bind fixed_point_alu fxa_checker u_fxa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
